// ===== hdl/midi_note_sustain_tracker_defines.svh =====
// assertion macros used by the back end of the note sustain tracker rtl
`ifndef MIDI_NOTE_SUSTAIN_TRACKER_DEFINES_SVH
`define MIDI_NOTE_SUSTAIN_TRACKER_DEFINES_SVH

`ifndef SYNTH
// checked property, off while reset is asserted
`define MNST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mnst assertion failed");
// checked property, also checked while reset is asserted
`define MNST_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("mnst assertion failed");
`else
`define MNST_ASSERT(lbl, clk, rst_n, prop)
`define MNST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/mnst_pkg.sv =====
// types, codes and constants of the note sustain tracker
`timescale 1ns / 1ps
package mnst_pkg;

	localparam int NOTE_COUNT_DEF    = 128;
	localparam int CHANNEL_COUNT_DEF = 16;
	localparam int GROUP_WIDTH_DEF   = 16;

	// note number space and the widest split of a note into group and offset
	localparam int NOTE_SPACE  = 128;
	localparam int GRP_IDX_W   = 4;
	localparam int OFF_IDX_W   = 6;
	localparam int MASK_W      = 16;
	localparam int VEL_W       = 7;
	localparam int CH_W        = 4;
	localparam int OUT_GRP_W   = 3;

	localparam int MAX_GROUP_RESULTS = 8;
	localparam int OPQ_DEPTH         = 2;
	localparam int RESQ_DEPTH        = 4;

	typedef enum logic [2:0] {
		CMD_NOTE_ON    = 3'd0,
		CMD_NOTE_OFF   = 3'd1,
		CMD_PEDAL_DOWN = 3'd2,
		CMD_PEDAL_UP   = 3'd3,
		CMD_ALL_OFF    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_NOTE_ON    = 3'd0,
		KIND_NOTE_OFF   = 3'd1,
		KIND_RELEASE    = 3'd2,
		KIND_PEDAL_DOWN = 3'd3,
		KIND_PEDAL_UP   = 3'd4
	} kind_t;

	// classified command handed from the front to the back
	typedef struct packed {
		cmd_t                 cmd;
		logic [CH_W-1:0]      ch;
		logic [GRP_IDX_W-1:0] grp;
		logic [OFF_IDX_W-1:0] off;
		logic [VEL_W-1:0]     vel;
		logic                 sus;
	} op_t;

	typedef struct packed {
		kind_t                kind;
		logic [CH_W-1:0]      ch;
		logic [OUT_GRP_W-1:0] grp;
		logic [MASK_W-1:0]    mask;
		logic [VEL_W-1:0]     vel;
		logic                 last;
	} res_t;

	typedef struct packed {
		logic [GRP_IDX_W-1:0] grp;
		logic [OFF_IDX_W-1:0] off;
	} split_t;

	typedef split_t [NOTE_SPACE-1:0] split_lut_t;

	// note -> group and offset, built by counting so no divider is needed
	function automatic split_lut_t build_split_lut(input int unsigned gw);
		split_lut_t  lut;
		int unsigned g;
		int unsigned r;
		g = 0;
		r = 0;
		for (int n = 0; n < NOTE_SPACE; n++) begin
			lut[n].grp = GRP_IDX_W'(g);
			lut[n].off = OFF_IDX_W'(r);
			r = r + 1;
			if (r == gw) begin
				r = 0;
				g = g + 1;
			end
		end
		return lut;
	endfunction

endpackage

// ===== hdl/mnst_fifo.sv =====
// small first-in first-out word queue
`timescale 1ns / 1ps
module mnst_fifo #(
	parameter int  DEPTH = 2,
	parameter type T     = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

// ===== hdl/mnst_front.sv =====
// command intake: range checks, pedal bookkeeping and note split
`timescale 1ns / 1ps
module mnst_front import mnst_pkg::*; #(
	parameter int NOTE_COUNT    = NOTE_COUNT_DEF,
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int GROUP_WIDTH   = GROUP_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [2:0]       command,
	input  logic [CH_W-1:0]  channel,
	input  logic [6:0]       note,
	input  logic [VEL_W-1:0] velocity,
	output logic             op_push,
	output op_t              op_data,
	input  logic             op_full
);

	localparam split_lut_t SPLIT_LUT = build_split_lut(GROUP_WIDTH);
	localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic [CHANNEL_COUNT-1:0] pedal_q;
	logic [CHANNEL_COUNT-1:0] ch_bit;
	logic                     ch_ok;
	logic                     note_ok;
	logic                     ped_cur;
	logic                     keep;
	cmd_t                     cmd;
	split_t                   split;

	assign cmd     = cmd_t'(command);
	assign ch_ok   = {1'b0, channel} < 5'(CHANNEL_COUNT);
	assign note_ok = {1'b0, note} < 8'(NOTE_COUNT);
	assign ped_cur = ch_ok ? pedal_q[channel[CH_IDX_W-1:0]] : 1'b0;
	assign ch_bit  = CHANNEL_COUNT'(1) << channel[CH_IDX_W-1:0];
	assign split   = SPLIT_LUT[note];

	always_comb begin
		keep = 1'b0;
		case (cmd)
			CMD_NOTE_ON:    keep = ch_ok && note_ok;
			CMD_NOTE_OFF:   keep = ch_ok && note_ok;
			CMD_PEDAL_DOWN: keep = ch_ok && !ped_cur;
			CMD_PEDAL_UP:   keep = ch_ok && ped_cur;
			CMD_ALL_OFF:    keep = ch_ok;
			default:        keep = 1'b0;
		endcase
	end

	assign full    = op_full;
	assign op_push = push && !op_full && keep;

	always_comb begin
		op_data.cmd = cmd;
		op_data.ch  = channel;
		op_data.grp = split.grp;
		op_data.off = split.off;
		op_data.vel = velocity;
		op_data.sus = ped_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedal_q <= '0;
		end else if (op_push) begin
			if (cmd == CMD_PEDAL_DOWN) pedal_q <= pedal_q | ch_bit;
			else if (cmd == CMD_PEDAL_UP) pedal_q <= pedal_q & ~ch_bit;
		end
	end

endmodule

// ===== hdl/mnst_back.sv =====
// key store and sequencer: row read-modify-write and result generation
`timescale 1ns / 1ps
`include "midi_note_sustain_tracker_defines.svh"
module mnst_back import mnst_pkg::*; #(
	parameter int NOTE_COUNT    = NOTE_COUNT_DEF,
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int GROUP_WIDTH   = GROUP_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_empty,
	input  op_t  op_data,
	output logic op_pop,
	output logic res_push,
	output res_t res_data,
	input  logic res_full
);

	localparam int GROUP_COUNT = (NOTE_COUNT + GROUP_WIDTH - 1) / GROUP_WIDTH;
	localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int DEPTH       = CHANNEL_COUNT * (1 << GRP_W);
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int OFF_W       = $clog2(GROUP_WIDTH);
	localparam int CNT_W       = $clog2(MAX_GROUP_RESULTS + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_MOD    = 5'b00100,
		S_NOTICE = 5'b01000,
		S_FLUSH  = 5'b10000
	} state_t;

	state_t                     state_q;
	state_t                     nxt_state;
	logic [GRP_W-1:0]           g_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       pend_v_q;
	res_t                       pend_q;

	// row: sustained keys above held keys
	logic [2*GROUP_WIDTH-1:0]   mem [DEPTH];
	logic [DEPTH-1:0]           row_v_q;
	logic [2*GROUP_WIDTH-1:0]   rd_row_q;
	logic                       rd_v_q;

	logic [GRP_W-1:0]           grp_sel;
	logic [ADDR_W-1:0]          addr;
	logic [GROUP_WIDTH-1:0]     held;
	logic [GROUP_WIDTH-1:0]     sust;
	logic [GROUP_WIDTH-1:0]     onehot;
	logic [GROUP_WIDTH-1:0]     new_held;
	logic [GROUP_WIDTH-1:0]     new_sust;
	logic [GROUP_WIDTH-1:0]     m_mask;
	logic [GRP_IDX_W-1:0]       m_grp;
	logic [VEL_W-1:0]           m_vel;
	kind_t                      m_kind;
	logic                       m_gen;
	logic                       wr_need;
	logic                       wr_en;
	logic                       walk;
	logic                       walk_done;
	logic                       room;
	logic                       gen;
	logic                       stall;
	res_t                       gen_res;

	assign walk      = (op_data.cmd == CMD_PEDAL_DOWN) || (op_data.cmd == CMD_PEDAL_UP) ||
	                   (op_data.cmd == CMD_ALL_OFF);
	assign walk_done = (g_q == GRP_W'(GROUP_COUNT - 1));
	assign room      = (cnt_q < CNT_W'(MAX_GROUP_RESULTS));
	assign grp_sel   = walk ? g_q : op_data.grp[GRP_W-1:0];
	assign addr      = ADDR_W'({op_data.ch, grp_sel});
	assign held      = rd_v_q ? rd_row_q[GROUP_WIDTH-1:0] : '0;
	assign sust      = rd_v_q ? rd_row_q[2*GROUP_WIDTH-1:GROUP_WIDTH] : '0;
	assign onehot    = GROUP_WIDTH'(1) << op_data.off[OFF_W-1:0];

	// per-row update and the result it raises
	always_comb begin
		m_gen    = 1'b0;
		m_kind   = KIND_NOTE_ON;
		m_mask   = '0;
		m_vel    = '0;
		m_grp    = GRP_IDX_W'(g_q);
		wr_need  = 1'b0;
		new_held = held;
		new_sust = sust;
		case (op_data.cmd)
			CMD_NOTE_ON: begin
				new_held = held | onehot;
				if (op_data.sus) new_sust = sust | onehot;
				wr_need = 1'b1;
				m_gen   = 1'b1;
				m_mask  = onehot;
				m_vel   = op_data.vel;
				m_grp   = op_data.grp;
			end
			CMD_NOTE_OFF: begin
				new_held = held & ~onehot;
				wr_need  = |(held & onehot);
				m_gen    = |(held & onehot);
				m_kind   = KIND_NOTE_OFF;
				m_mask   = onehot;
				m_vel    = op_data.vel;
				m_grp    = op_data.grp;
			end
			CMD_PEDAL_DOWN: begin
				new_sust = sust | held;
				wr_need  = 1'b1;
			end
			CMD_PEDAL_UP: begin
				new_sust = '0;
				wr_need  = 1'b1;
				m_mask   = sust & ~held;
				m_gen    = (|(sust & ~held)) && room;
				m_kind   = KIND_RELEASE;
			end
			CMD_ALL_OFF: begin
				new_held = '0;
				wr_need  = 1'b1;
				m_mask   = held;
				m_gen    = (|held) && room;
				m_kind   = KIND_NOTE_OFF;
			end
			default: ;
		endcase
	end

	assign gen = ((state_q == S_MOD) && m_gen) || (state_q == S_NOTICE);

	always_comb begin
		gen_res.kind = m_kind;
		gen_res.ch   = op_data.ch;
		gen_res.grp  = m_grp[OUT_GRP_W-1:0];
		gen_res.mask = MASK_W'(m_mask);
		gen_res.vel  = m_vel;
		gen_res.last = 1'b0;
		if (state_q == S_NOTICE) begin
			gen_res.kind = (op_data.cmd == CMD_PEDAL_DOWN) ? KIND_PEDAL_DOWN : KIND_PEDAL_UP;
			gen_res.grp  = '0;
			gen_res.mask = '0;
			gen_res.vel  = '0;
		end
	end

	// a new result pushes the pending one out, so it needs queue room
	assign stall = gen && pend_v_q && res_full;
	assign wr_en = (state_q == S_MOD) && !stall && wr_need;

	always_comb begin
		nxt_state = state_q;
		op_pop    = 1'b0;
		case (state_q)
			S_IDLE: if (!op_empty) nxt_state = S_READ;
			S_READ: nxt_state = S_MOD;
			S_MOD: begin
				if (!stall) begin
					if (!walk) nxt_state = S_FLUSH;
					else if (!walk_done) nxt_state = S_READ;
					else if (op_data.cmd == CMD_ALL_OFF) nxt_state = S_FLUSH;
					else nxt_state = S_NOTICE;
				end
			end
			S_NOTICE: if (!stall) nxt_state = S_FLUSH;
			S_FLUSH: begin
				if (!pend_v_q || !res_full) begin
					nxt_state = S_IDLE;
					op_pop    = 1'b1;
				end
			end
			default: nxt_state = S_IDLE;
		endcase
	end

	assign res_push = pend_v_q && !res_full && ((gen && !stall) || (state_q == S_FLUSH));

	always_comb begin
		res_data      = pend_q;
		res_data.last = (state_q == S_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			g_q      <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			row_v_q  <= '0;
			rd_v_q   <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (state_q == S_IDLE) begin
				g_q   <= '0;
				cnt_q <= '0;
			end else if ((state_q == S_MOD) && !stall && walk) begin
				if (!walk_done) g_q <= g_q + 1'b1;
				if (m_gen) cnt_q <= cnt_q + 1'b1;
			end
			if (gen && !stall) pend_v_q <= 1'b1;
			else if (op_pop) pend_v_q <= 1'b0;
			if (state_q == S_READ) rd_v_q <= row_v_q[addr];
			if (wr_en) row_v_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (gen && !stall) pend_q <= gen_res;
		if (state_q == S_READ) rd_row_q <= mem[addr];
		if (wr_en) mem[addr] <= {new_sust, new_held};
	end

	`MNST_ASSERT(a_push_has_room, clk, arst_n, res_push |-> !res_full)
	`MNST_ASSERT(a_group_cap, clk, arst_n, cnt_q <= CNT_W'(MAX_GROUP_RESULTS))
	`MNST_ASSERT(a_idle_no_pending, clk, arst_n, (state_q == S_IDLE) |-> !pend_v_q)
	`MNST_ASSERT(a_pop_from_flush, clk, arst_n, op_pop |-> (state_q == S_FLUSH) && !op_empty)
	`MNST_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> (state_q == S_IDLE) && !pend_v_q)

endmodule

// ===== hdl/midi_note_sustain_tracker.sv =====
// top level of the midi key and sustain pedal tracker
`timescale 1ns / 1ps
// path: a note on or note off word passes the command queue, the sequencer's read, modify and
// flush states and the result queue; pedal and all-notes-off walk every note group with one
//   read-modify-write of the key store per group, and pedal then adds a notice state
//   (8 groups at 128 notes in groups of 16); the sequencer takes one command at a time
// the single-port key store row update sets the rate; a 2-word command queue lets intake run ahead
// reset: queues, pedal bits, sequencer and row valid bits clear at once; rows read as zero
module midi_note_sustain_tracker import mnst_pkg::*; #(
	parameter int NOTE_COUNT    = NOTE_COUNT_DEF,
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	parameter int GROUP_WIDTH   = GROUP_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command words
	input  logic                 push,
	output logic                 full,
	input  logic [2:0]           command,
	input  logic [CH_W-1:0]      channel,
	input  logic [6:0]           note,
	input  logic [VEL_W-1:0]     velocity,
	// result words
	output logic                 empty,
	input  logic                 pop,
	output logic [2:0]           kind,
	output logic [CH_W-1:0]      out_channel,
	output logic [OUT_GRP_W-1:0] group,
	output logic [MASK_W-1:0]    note_mask,
	output logic [VEL_W-1:0]     out_velocity,
	output logic                 last
);

	// front to command queue
	logic op_in_push;
	op_t  op_in_data;
	logic op_in_full;

	// command queue to back end
	logic op_empty;
	op_t  op_head;
	logic op_pop;

	// back end to result queue
	logic res_push;
	res_t res_in;
	logic res_full;
	res_t res_head;

	// intake: drops words it can see cause nothing (bad channel, note or command,
	// pedal already in the asked position) and keeps the pedal bits
	mnst_front #(
		.NOTE_COUNT   (NOTE_COUNT),
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.GROUP_WIDTH  (GROUP_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.command (command),
		.channel (channel),
		.note    (note),
		.velocity(velocity),
		.op_push (op_in_push),
		.op_data (op_in_data),
		.op_full (op_in_full)
	);

	// decouples intake from the key store sequencer
	mnst_fifo #(
		.DEPTH(OPQ_DEPTH),
		.T    (op_t)
	) u_op_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (op_in_push),
		.din   (op_in_data),
		.full  (op_in_full),
		.pop   (op_pop),
		.dout  (op_head),
		.empty (op_empty)
	);

	// key store: one row per channel and note group, held and sustained bits;
	// a result is kept pending until the next one or the end of the command
	// so that the final one can carry the last flag
	mnst_back #(
		.NOTE_COUNT   (NOTE_COUNT),
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.GROUP_WIDTH  (GROUP_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_empty(op_empty),
		.op_data (op_head),
		.op_pop  (op_pop),
		.res_push(res_push),
		.res_data(res_in),
		.res_full(res_full)
	);

	// result words wait here so the sequencer keeps going while the reader stalls
	mnst_fifo #(
		.DEPTH(RESQ_DEPTH),
		.T    (res_t)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_head),
		.empty (empty)
	);

	assign kind         = res_head.kind;
	assign out_channel  = res_head.ch;
	assign group        = res_head.grp;
	assign note_mask    = res_head.mask;
	assign out_velocity = res_head.vel;
	assign last         = res_head.last;

endmodule

// ===== test/testbench.sv =====
// testbench for the midi key and sustain pedal tracker
`timescale 1ns / 1ps
module testbench;
	import mnst_pkg::*;

	// one command word as it is offered on the push side
	typedef struct {
		logic [2:0] command;
		logic [3:0] channel;
		logic [6:0] note;
		logic [6:0] velocity;
		bit         drain;    // hold this word back until every notice is in
	} cmd_word_t;

	// one notice word as it should show on the pop side
	typedef struct {
		kind_t       kind;
		logic [3:0]  channel;
		logic [2:0]  group;
		logic [15:0] mask;
		logic [6:0]  velocity;
		logic        last;
	} notice_t;

	localparam int RANDOM_WORDS = 480;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int SETTLE_CYCLES = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  command = '0;
	logic [3:0]  channel = '0;
	logic [6:0]  note = '0;
	logic [6:0]  velocity = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  kind;
	logic [3:0]  out_channel;
	logic [2:0]  group;
	logic [15:0] note_mask;
	logic [6:0]  out_velocity;
	logic        last;

	midi_note_sustain_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.channel(channel),
		.note(note),
		.velocity(velocity),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.out_channel(out_channel),
		.group(group),
		.note_mask(note_mask),
		.out_velocity(out_velocity),
		.last(last)
	);

	// words still to send, and notices still owed by the block
	cmd_word_t queued_commands[$];
	notice_t   owed_notices[$];

	// key state as the block should hold it: bit c of an entry is channel c
	logic [15:0] key_held [128];
	logic [15:0] key_sustained [128];
	logic [15:0] pedal_down;

	// generator-side view of held keys, used to pick sensible note offs
	logic [127:0] gen_held [16];

	int words_sent = 0;
	int error_count = 0;
	int hold_left = 0;
	bit holdoff_done = 0;
	bit offer;

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		// keep the log short if the block is badly off
		if (error_count <= 40)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic notice_t make_notice(kind_t k, logic [3:0] ch, logic [2:0] grp,
		logic [15:0] mask, logic [6:0] vel);
		notice_t n;
		n.kind = k;
		n.channel = ch;
		n.group = grp;
		n.mask = mask;
		n.velocity = vel;
		n.last = 1'b0;
		return n;
	endfunction

	// apply one accepted word to the key state and queue the notices it owes
	task automatic track_keys(input cmd_word_t w);
		logic [15:0] chbit;
		logic [15:0] m;
		notice_t     burst[$];
		chbit = 16'd1 << w.channel;
		case (w.command)
			CMD_NOTE_ON: begin
				key_held[w.note] |= chbit;
				if ((pedal_down & chbit) != 0)
					key_sustained[w.note] |= chbit;
				burst.push_back(make_notice(KIND_NOTE_ON, w.channel, w.note[6:4],
					16'd1 << w.note[3:0], w.velocity));
			end
			CMD_NOTE_OFF: begin
				// a key that is not down gives nothing
				if ((key_held[w.note] & chbit) != 0) begin
					key_held[w.note] &= ~chbit;
					burst.push_back(make_notice(KIND_NOTE_OFF, w.channel, w.note[6:4],
						16'd1 << w.note[3:0], w.velocity));
				end
			end
			CMD_PEDAL_DOWN: begin
				if ((pedal_down & chbit) == 0) begin
					pedal_down |= chbit;
					for (int n = 0; n < 128; n++)
						if ((key_held[n] & chbit) != 0)
							key_sustained[n] |= chbit;
					burst.push_back(make_notice(KIND_PEDAL_DOWN, w.channel, '0, '0, '0));
				end
			end
			CMD_PEDAL_UP: begin
				if ((pedal_down & chbit) != 0) begin
					pedal_down &= ~chbit;
					// release notices for keys kept only by the pedal
					for (int g = 0; g < 8; g++) begin
						m = '0;
						for (int j = 0; j < 16; j++)
							m[j] = ((key_sustained[g*16+j] & chbit) != 0) &&
								((key_held[g*16+j] & chbit) == 0);
						if (m != 0)
							burst.push_back(make_notice(KIND_RELEASE, w.channel, g[2:0], m, '0));
					end
					for (int n = 0; n < 128; n++)
						key_sustained[n] &= ~chbit;
					burst.push_back(make_notice(KIND_PEDAL_UP, w.channel, '0, '0, '0));
				end
			end
			CMD_ALL_OFF: begin
				for (int g = 0; g < 8; g++) begin
					m = '0;
					for (int j = 0; j < 16; j++)
						m[j] = (key_held[g*16+j] & chbit) != 0;
					if (m != 0)
						burst.push_back(make_notice(KIND_NOTE_OFF, w.channel, g[2:0], m, '0));
				end
				for (int n = 0; n < 128; n++)
					key_held[n] &= ~chbit;
			end
			default: ;  // undefined command codes are dropped
		endcase
		if (burst.size() > 0)
			burst[burst.size()-1].last = 1'b1;
		foreach (burst[i])
			owed_notices.push_back(burst[i]);
	endtask

	// idle percentages per phase: sender mostly busy first, then receiver, then both
	function automatic int sender_idle_pct();
		if (words_sent < 160)
			return 6;
		else if (words_sent < 320)
			return 86;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (words_sent < 160)
			return 86;
		else if (words_sent < 320)
			return 6;
		return 0;
	endfunction

	task automatic enqueue(input logic [2:0] cmd, input logic [3:0] ch, input logic [6:0] nt,
		input logic [6:0] vel);
		cmd_word_t w;
		w.command = cmd;
		w.channel = ch;
		w.note = nt;
		w.velocity = vel;
		w.drain = 0;
		queued_commands.push_back(w);
		if (cmd == CMD_NOTE_ON)
			gen_held[ch][nt] = 1'b1;
		else if (cmd == CMD_NOTE_OFF)
			gen_held[ch][nt] = 1'b0;
		else if (cmd == CMD_ALL_OFF)
			gen_held[ch] = '0;
	endtask

	// a key the generator believes is down, or any key if none is
	function automatic logic [6:0] pick_held(input logic [3:0] ch);
		int start;
		start = $urandom_range(127);
		for (int i = 0; i < 128; i++)
			if (gen_held[ch][(start + i) % 128])
				return 7'((start + i) % 128);
		return 7'($urandom_range(127));
	endfunction

	function automatic logic [6:0] rand_vel();
		return 7'($urandom_range(127));
	endfunction

	// stimulus: directed words first, then random phrases
	initial begin
		int          pick;
		int          cnt;
		logic [3:0]  ch;
		bit          mid_drain;
		mid_drain = 0;
		for (int c = 0; c < 16; c++)
			gen_held[c] = '0;
		for (int n = 0; n < 128; n++) begin
			key_held[n] = '0;
			key_sustained[n] = '0;
		end
		pedal_down = '0;

		// extremes of note, channel and velocity
		enqueue(CMD_NOTE_ON, 4'd0, 7'd0, 7'd0);
		enqueue(CMD_NOTE_ON, 4'd15, 7'd127, 7'd127);
		enqueue(CMD_NOTE_OFF, 4'd0, 7'd0, 7'd127);
		// note off of a key that is up, pedal up while already up
		enqueue(CMD_NOTE_OFF, 4'd3, 7'd5, 7'd33);
		enqueue(CMD_PEDAL_UP, 4'd2, 7'd0, 7'd0);
		// pedal down twice, the second one is silent
		enqueue(CMD_PEDAL_DOWN, 4'd15, 7'd0, 7'd0);
		enqueue(CMD_PEDAL_DOWN, 4'd15, 7'd99, 7'd12);
		enqueue(CMD_NOTE_ON, 4'd15, 7'd64, 7'd1);
		enqueue(CMD_NOTE_OFF, 4'd15, 7'd127, 7'd85);
		// release of the key kept only by the pedal, then the pedal notice
		enqueue(CMD_PEDAL_UP, 4'd15, 7'd0, 7'd0);
		enqueue(CMD_ALL_OFF, 4'd15, 7'd0, 7'd0);
		// all notes off with nothing down
		enqueue(CMD_ALL_OFF, 4'd7, 7'd0, 7'd0);
		// undefined command codes
		enqueue(3'd5, 4'd1, 7'd42, 7'd42);
		enqueue(3'd6, 4'd5, 7'd0, 7'd127);
		enqueue(3'd7, 4'd10, 7'd127, 7'd127);
		// all notes off over several groups
		enqueue(CMD_NOTE_ON, 4'd9, 7'd15, 7'd100);
		enqueue(CMD_NOTE_ON, 4'd9, 7'd16, 7'd101);
		enqueue(CMD_NOTE_ON, 4'd9, 7'd85, 7'd102);
		enqueue(CMD_NOTE_ON, 4'd9, 7'd112, 7'd103);
		enqueue(CMD_ALL_OFF, 4'd9, 7'd55, 7'd77);
		enqueue(CMD_NOTE_ON, 4'd6, 7'h55, 7'h2a);
		enqueue(CMD_NOTE_ON, 4'd6, 7'h2a, 7'h55);
		queued_commands[$].drain = 1;

		cnt = queued_commands.size();
		while (queued_commands.size() < cnt + RANDOM_WORDS) begin
			pick = $urandom_range(99);
			ch = 4'($urandom_range(15));
			if (pick < 35) begin
				// pedal phrase: down, a few keys, some lifted, up
				enqueue(CMD_PEDAL_DOWN, ch, 7'($urandom_range(127)), rand_vel());
				repeat ($urandom_range(6, 1))
					enqueue(CMD_NOTE_ON, ch, 7'($urandom_range(127)), rand_vel());
				repeat ($urandom_range(4))
					enqueue(CMD_NOTE_OFF, ch, pick_held(ch), rand_vel());
				enqueue(CMD_PEDAL_UP, ch, 7'($urandom_range(127)), rand_vel());
			end else if (pick < 55) begin
				// chord phrase ended by all notes off
				repeat ($urandom_range(6, 1))
					enqueue(CMD_NOTE_ON, ch, 7'($urandom_range(127)), rand_vel());
				repeat ($urandom_range(2))
					enqueue(CMD_NOTE_OFF, ch, pick_held(ch), rand_vel());
				enqueue(CMD_ALL_OFF, ch, 7'($urandom_range(127)), rand_vel());
			end else if (pick < 61) begin
				// one key per group: pedal up then yields the longest burst
				enqueue(CMD_PEDAL_DOWN, ch, 7'd0, 7'd0);
				for (int g = 0; g < 8; g++)
					enqueue(CMD_NOTE_ON, ch, 7'(g*16 + $urandom_range(15)), rand_vel());
				if ($urandom_range(1)) begin
					for (int g = 0; g < 8; g++)
						enqueue(CMD_NOTE_OFF, ch, pick_held(ch), rand_vel());
					enqueue(CMD_PEDAL_UP, ch, 7'd0, 7'd0);
				end else begin
					enqueue(CMD_ALL_OFF, ch, 7'd0, 7'd0);
					enqueue(CMD_PEDAL_UP, ch, 7'd0, 7'd0);
				end
			end else if (pick < 80) begin
				enqueue(CMD_NOTE_OFF, ch, pick_held(ch), rand_vel());
			end else begin
				// noise: any code, any key
				enqueue(3'($urandom_range(7)), ch, 7'($urandom_range(127)), rand_vel());
			end
			if (!mid_drain && queued_commands.size() >= cnt + RANDOM_WORDS / 2) begin
				queued_commands[$].drain = 1;
				mid_drain = 1;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_commands.size() != 0 || owed_notices.size() != 0)
			@(posedge clk);
		// a walk over the key store may still be running with nothing owed
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// driver: keeps a word on the bus until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			command <= '0;
			channel <= '0;
			note <= '0;
			velocity <= '0;
		end else begin
			if (push && !full) begin
				track_keys(queued_commands[0]);
				void'(queued_commands.pop_front());
				words_sent++;
			end
			offer = 1'b0;
			if (queued_commands.size() > 0) begin
				if (push && full)
					offer = 1'b1;
				else if (queued_commands[0].drain && owed_notices.size() != 0)
					offer = 1'b0;
				else
					offer = $urandom_range(99) >= sender_idle_pct();
			end
			push <= offer;
			if (offer) begin
				command <= queued_commands[0].command;
				channel <= queued_commands[0].channel;
				note <= queued_commands[0].note;
				velocity <= queued_commands[0].velocity;
			end
		end
	end

	// monitor: checks each popped word against the oldest owed notice
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (owed_notices.size() == 0) begin
					report_mismatch($sformatf("unexpected word kind %0d ch %0d grp %0d mask %h",
						kind, out_channel, group, note_mask));
				end else begin
					if (kind !== owed_notices[0].kind)
						report_mismatch($sformatf("kind %0d, want %0d", kind,
							owed_notices[0].kind));
					if (out_channel !== owed_notices[0].channel)
						report_mismatch($sformatf("out_channel %0d, want %0d", out_channel,
							owed_notices[0].channel));
					if (group !== owed_notices[0].group)
						report_mismatch($sformatf("group %0d, want %0d", group,
							owed_notices[0].group));
					if (note_mask !== owed_notices[0].mask)
						report_mismatch($sformatf("note_mask %h, want %h", note_mask,
							owed_notices[0].mask));
					if (out_velocity !== owed_notices[0].velocity)
						report_mismatch($sformatf("out_velocity %0d, want %0d", out_velocity,
							owed_notices[0].velocity));
					if (last !== owed_notices[0].last)
						report_mismatch($sformatf("last %b, want %b", last,
							owed_notices[0].last));
					void'(owed_notices.pop_front());
				end
			end
			// one long stall early on so both queues of the block fill up
			if (!holdoff_done && words_sent >= 60) begin
				hold_left = HOLDOFF_CYCLES;
				holdoff_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= $urandom_range(99) >= receiver_idle_pct();
			end
		end
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mnst_pkg.sv
hdl/mnst_fifo.sv
hdl/mnst_front.sv
hdl/mnst_back.sv
hdl/midi_note_sustain_tracker.sv
test/testbench.sv
